// ----- hdl/rau_pkg.sv -----
// Package with the shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned CNT_W       = $clog2(WIDE_W + 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_SIGN,
    S_GCD_GO, S_GCD, S_DIVN_GO, S_DIVN, S_DIVD_GO, S_DIVD, S_FIN
  } state_e;

  // Handshake between the sequencer and an iterative unit.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

// ----- hdl/rau_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module rau_mul (
  input  logic                          clk_i,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] a_i,
  input  logic signed [rau_pkg::VALUE_WIDTH-1:0] b_i,
  output logic signed [rau_pkg::WIDE_W-1:0]      prod_o
);
  import rau_pkg::*;

  // Both operands are sign-extended to the product width by the assignment context.
  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

// ----- hdl/rau_gcd.sv -----
// Iterative binary greatest common divisor, one shift or subtract per cycle.
`timescale 1ns / 1ps
module rau_gcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rau_pkg::unit_req_t           req_i,
  input  logic [rau_pkg::WIDE_W-1:0]   a_i,
  input  logic [rau_pkg::WIDE_W-1:0]   b_i,
  output rau_pkg::unit_rsp_t           rsp_o,
  output logic [rau_pkg::WIDE_W-1:0]   gcd_o
);
  import rau_pkg::*;

  logic [WIDE_W-1:0] a_q, b_q;
  logic [CNT_W-1:0]  k_q;
  logic              busy_q, done_q;

  // Both operands are nonzero when started, so the loop always ends at a equal b.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (a_q == b_q)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        gcd_o <= a_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + CNT_W'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

  assign rsp_o.done = done_q;

endmodule

// ----- hdl/rau_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rau_pkg::unit_req_t           req_i,
  input  logic [rau_pkg::WIDE_W-1:0]   dividend_i,
  input  logic [rau_pkg::WIDE_W-1:0]   divisor_i,
  output rau_pkg::unit_rsp_t           rsp_o,
  output logic [rau_pkg::WIDE_W-1:0]   quot_o
);
  import rau_pkg::*;

  logic [WIDE_W:0]   rem_q;
  logic [WIDE_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [WIDE_W:0]   shifted;
  logic [WIDE_W:0]   trial;

  assign shifted = {rem_q[WIDE_W-1:0], quot_o[WIDE_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WIDE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      quot_o <= dividend_i;
    end else if (busy_q) begin
      if (!trial[WIDE_W]) begin
        rem_q  <= trial;
        quot_o <= {quot_o[WIDE_W-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        quot_o <= {quot_o[WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;

endmodule

// ----- hdl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: sequencer and result registers.
`timescale 1ns / 1ps
// An item is transferred at a clock edge with start high and busy low. Compare,
// unused opcodes and operands that divide by zero give their result in the next
// cycle. Other items run through one shared multiplier (three products), a
// binary GCD and two divisions on one shared divider; a zero numerator skips
// the GCD and divisions. Busy stays high for the whole run. The result is shown
// for exactly one cycle with valid_o high and cannot be held off by the receiver.
module rational_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic signed [31:0] lhs_num_i,
  input  logic [30:0] lhs_den_i,
  input  logic signed [31:0] rhs_num_i,
  input  logic [30:0] rhs_den_i,
  output logic        valid_o,
  output logic signed [31:0] result_num_o,
  output logic [30:0] result_den_o,
  output logic        is_equal_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (VALUE_WIDTH - 1);

  state_e state_q, state_d;

  logic [2:0]  op_q;
  logic signed [31:0] ln_q, rn_q, ld_q, rd_q;
  logic signed [WIDE_W-1:0] t0_q, t1_q, t2_q, num_q, den_q;
  logic [WIDE_W-1:0] mn_q, md_q, g_q;
  logic neg_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [WIDE_W-1:0] prod;
  unit_req_t gcd_req, div_req;
  unit_rsp_t gcd_rsp, div_rsp;
  logic [WIDE_W-1:0] gcd_res, quot, div_dividend;

  logic accept, quick, dz;
  logic ovf;

  assign accept = start && !busy;
  assign dz = (lhs_den_i == '0) || (rhs_den_i == '0) ||
              ((opcode_i == OP_DIV) && (rhs_num_i == '0));
  // Items that need no arithmetic are answered right at the transfer.
  assign quick = (opcode_i > OP_DIV) || dz;
  assign busy = (state_q != S_IDLE);

  rau_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  rau_gcd u_gcd (.clk_i, .rst_ni, .req_i(gcd_req), .a_i(mn_q), .b_i(md_q),
                 .rsp_o(gcd_rsp), .gcd_o(gcd_res));

  rau_div u_div (.clk_i, .rst_ni, .req_i(div_req), .dividend_i(div_dividend),
                 .divisor_i(g_q), .rsp_o(div_rsp), .quot_o(quot));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept && !quick) state_d = S_MUL0;
      S_MUL0:    state_d = S_MUL1;
      S_MUL1:    state_d = S_MUL2;
      S_MUL2:    state_d = S_MUL3;
      S_MUL3:    state_d = S_COMB;
      S_COMB:    state_d = S_SIGN;
      S_SIGN:    state_d = (num_q == '0) ? S_FIN : S_GCD_GO;
      S_GCD_GO:  state_d = S_GCD;
      S_GCD:     if (gcd_rsp.done) state_d = S_DIVN_GO;
      S_DIVN_GO: state_d = S_DIVN;
      S_DIVN:    if (div_rsp.done) state_d = S_DIVD_GO;
      S_DIVD_GO: state_d = S_DIVD;
      S_DIVD:    if (div_rsp.done) state_d = S_FIN;
      S_FIN:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mul_a = ld_q;
    mul_b = rd_q;
    gcd_req.start = 1'b0;
    div_req.start = 1'b0;
    div_dividend = mn_q;
    case (state_q)
      S_MUL0: begin
        mul_a = ln_q;
        mul_b = (op_q == OP_MUL) ? rn_q : rd_q;
      end
      S_MUL1: begin
        mul_a = (op_q == OP_MUL) ? ld_q : rn_q;
        mul_b = (op_q == OP_MUL) ? rd_q : ld_q;
      end
      S_GCD_GO:  gcd_req.start = 1'b1;
      S_DIVN_GO: div_req.start = 1'b1;
      S_DIVD_GO: begin
        div_req.start = 1'b1;
        div_dividend = md_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (accept && quick) || (state_q == S_FIN);
    end
  end

  assign ovf = (neg_q ? (mn_q > LIM) : (mn_q > LIM - 1'b1)) || (md_q > LIM - 1'b1);

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (accept) begin
        op_q <= opcode_i;
        ln_q <= lhs_num_i;
        rn_q <= rhs_num_i;
        ld_q <= {1'b0, lhs_den_i};
        rd_q <= {1'b0, rhs_den_i};
        result_num_o <= '0;
        result_den_o <= '0;
        is_equal_o   <= (opcode_i == OP_CMP) && (lhs_num_i == rhs_num_i) &&
                        (lhs_den_i == rhs_den_i);
        status_o     <= ((opcode_i <= OP_DIV) && dz) ? ST_DIV0 : ST_OK;
      end
      S_MUL1: t0_q <= prod;
      S_MUL2: t1_q <= prod;
      S_MUL3: t2_q <= prod;
      S_COMB: begin
        case (op_q)
          OP_ADD:  begin num_q <= t0_q + t1_q; den_q <= t2_q; end
          OP_SUB:  begin num_q <= t0_q - t1_q; den_q <= t2_q; end
          default: begin num_q <= t0_q;        den_q <= t1_q; end
        endcase
      end
      S_SIGN: begin
        // Sign goes to the numerator; a zero numerator becomes 0/1.
        mn_q  <= num_q[WIDE_W-1] ? WIDE_W'(-num_q) : WIDE_W'(num_q);
        md_q  <= (num_q == '0) ? WIDE_W'(1)
               : (den_q[WIDE_W-1] ? WIDE_W'(-den_q) : WIDE_W'(den_q));
        neg_q <= (num_q != '0) && (num_q[WIDE_W-1] ^ den_q[WIDE_W-1]);
      end
      S_GCD:  if (gcd_rsp.done) g_q <= gcd_res;
      S_DIVN: if (div_rsp.done) mn_q <= quot;
      S_DIVD: if (div_rsp.done) md_q <= quot;
      S_FIN: begin
        is_equal_o <= 1'b0;
        if (ovf) begin
          result_num_o <= '0;
          result_den_o <= '0;
          status_o     <= ST_OVF;
        end else begin
          result_num_o <= neg_q ? 32'(-mn_q) : 32'(mn_q);
          result_den_o <= 31'(md_q);
          status_o     <= ST_OK;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK) |-> (result_num_o == '0) && (result_den_o == '0))
    else $error("error result carries a nonzero fraction");
  a_eq_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_equal_o |-> (status_o == ST_OK) && (result_den_o == '0))
    else $error("equality flag on a non-compare result");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o != 2'd3))
    else $error("undefined status code");
  a_busy_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> valid_o && !busy)
    else $error("finished item did not produce a result");
`endif

endmodule
